// File: rtl/hss_pkg.sv
package hss_pkg;

  // Fixed field widths.
  localparam int PROB_W      = 17;
  localparam int DEV_IN_W    = 16;
  localparam int KIND_W      = 3;
  localparam int ROW_W       = 4;
  localparam int SLOT_W      = 4;
  localparam int CNT_IN_W    = 5;
  localparam int OUT_IDX_W   = 4;
  localparam int NUM_W       = 5;
  localparam int SEQ_W       = 11;
  localparam int POS_W       = 10;
  localparam int SEQ_LEN_MAX = 1024;

  // Default sizes.
  localparam int DEF_MAX_STATES     = 16;
  localparam int DEF_MAX_SYMBOLS    = 16;
  localparam int DEF_MAX_OUT_DEGREE = 16;
  localparam int DEF_PROB_FRAC_BITS = 16;

  // Register file.
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_STATES  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_SYMBOLS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEQ_LENGTH  = 2'd2;

  localparam logic [NUM_W-1:0] NUM_STATES_RST  = 5'd16;
  localparam logic [NUM_W-1:0] NUM_SYMBOLS_RST = 5'd16;
  localparam logic [SEQ_W-1:0] SEQ_LENGTH_RST  = 11'd16;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_START = 3'd0,
    KIND_LOAD_EMIT  = 3'd1,
    KIND_LOAD_TRANS = 3'd2,
    KIND_LOAD_DEG   = 3'd3,
    KIND_GENERATE   = 3'd4
  } kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEG,
    ST_PICK,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/hmm_sequence_sampler.sv
// Channel    | Ports                                             | Direction
// -----------+---------------------------------------------------+----------
// input      | start, busy, in_kind .. in_emit_deviate           | in/out
// result     | out_valid, out_observation, out_hidden_state,     | out
//            | out_last_in_sequence                              |
// config     | psel, penable, pwrite, paddr, pwdata, prdata,     | in/out
//            | pready                                            |
//
// A load transaction gives no result. A generate transaction walks the start
// or transition list of up to k entries and then the emission row of up to m
// entries through one shared add-and-compare unit, one entry per cycle, fed by
// registered memory reads. After a transition the walk is preceded by the
// degree read in ST_DEG (a transition from a state with no slots walks
// nothing). busy is high until the strobe cycle. Reset is synchronous; the
// tables are not cleared. The receiver cannot stall.
module hmm_sequence_sampler #(
  parameter int MAX_STATES     = hss_pkg::DEF_MAX_STATES,
  parameter int MAX_SYMBOLS    = hss_pkg::DEF_MAX_SYMBOLS,
  parameter int MAX_OUT_DEGREE = hss_pkg::DEF_MAX_OUT_DEGREE,
  parameter int PROB_FRAC_BITS = hss_pkg::DEF_PROB_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hss_pkg::KIND_W-1:0]    in_kind,
  input  logic [hss_pkg::ROW_W-1:0]     in_row_state,
  input  logic [hss_pkg::SLOT_W-1:0]    in_slot,
  input  logic [hss_pkg::PROB_W-1:0]    in_prob,
  input  logic [hss_pkg::ROW_W-1:0]     in_target_state,
  input  logic [hss_pkg::CNT_IN_W-1:0]  in_out_count,
  input  logic [hss_pkg::DEV_IN_W-1:0]  in_state_deviate,
  input  logic [hss_pkg::DEV_IN_W-1:0]  in_emit_deviate,
  output logic                          out_valid,
  output logic [hss_pkg::OUT_IDX_W-1:0] out_observation,
  output logic [hss_pkg::OUT_IDX_W-1:0] out_hidden_state,
  output logic                          out_last_in_sequence,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hss_pkg::APB_AW-1:0]    paddr,
  input  logic [hss_pkg::APB_DW-1:0]    pwdata,
  output logic [hss_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int MAXDIM_A = (MAX_STATES > MAX_SYMBOLS) ? MAX_STATES : MAX_SYMBOLS;
  localparam int MAXDIM   = (MAXDIM_A > MAX_OUT_DEGREE) ? MAXDIM_A : MAX_OUT_DEGREE;
  localparam int ST_W     = $clog2(MAX_STATES);
  localparam int IDX_W    = $clog2(MAXDIM);
  localparam int CNT_W    = $clog2(MAXDIM + 1);
  localparam int DEG_W    = $clog2(MAX_OUT_DEGREE + 1);
  localparam int EM_DEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int TR_DEPTH = MAX_STATES * MAX_OUT_DEGREE;
  localparam int EM_AW    = $clog2(EM_DEPTH);
  localparam int TR_AW    = $clog2(TR_DEPTH);
  localparam int TR_DW    = ST_W + hss_pkg::PROB_W;
  localparam int DEV_W    = (PROB_FRAC_BITS > hss_pkg::DEV_IN_W) ? PROB_FRAC_BITS
                                                                 : hss_pkg::DEV_IN_W;
  localparam int DEV_SHL  = (PROB_FRAC_BITS > hss_pkg::DEV_IN_W)
                            ? PROB_FRAC_BITS - hss_pkg::DEV_IN_W : 0;
  localparam int DEV_SHR  = (PROB_FRAC_BITS < hss_pkg::DEV_IN_W)
                            ? hss_pkg::DEV_IN_W - PROB_FRAC_BITS : 0;
  localparam int SUM_W0   = hss_pkg::PROB_W + IDX_W + 1;
  localparam int SUM_W    = (SUM_W0 > DEV_W) ? SUM_W0 + 1 : DEV_W + 1;

  // Control state.
  hss_pkg::state_t state_r, state_nxt;
  logic [hss_pkg::NUM_W-1:0] num_states_r, num_symbols_r;
  logic [hss_pkg::SEQ_W-1:0] seq_length_r;
  logic [ST_W-1:0]           cur_state_r, cur_state_nxt;
  logic [hss_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      dvld_r, dvld_nxt;

  // Walk datapath.
  logic [IDX_W-1:0] iss_r, iss_nxt;
  logic [IDX_W-1:0] didx_r, didx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [DEV_W-1:0] sdev_r, sdev_nxt, edev_r, edev_nxt;
  logic             from_start_r, from_start_nxt;
  logic [hss_pkg::OUT_IDX_W-1:0] obs_r, obs_nxt, hid_r, hid_nxt;
  logic             last_r, last_nxt;

  // Memories and their registered read data.
  logic [hss_pkg::PROB_W-1:0] start_mem [MAX_STATES];
  logic [DEG_W-1:0]           deg_mem   [MAX_STATES];
  logic [hss_pkg::PROB_W-1:0] emis_mem  [EM_DEPTH];
  logic [TR_DW-1:0]           trans_mem [TR_DEPTH];
  logic [hss_pkg::PROB_W-1:0] start_q, emis_q;
  logic [DEG_W-1:0]           deg_q;
  logic [TR_DW-1:0]           trans_q;

  logic [EM_AW-1:0] emis_raddr, emis_waddr;
  logic [TR_AW-1:0] trans_raddr, trans_waddr;
  logic [ST_W-1:0]  row_idx, tgt_sat;
  logic [DEG_W-1:0] deg_sat;

  logic accept, gen_accept, row_ok;
  logic we_start, we_emis, we_trans, we_deg;
  logic cfg_we;
  logic [hss_pkg::REG_IDX_W-1:0] cfg_idx;

  logic [CNT_W-1:0] n_states_c, n_symbols_c, last_idx;
  logic [hss_pkg::SEQ_W-1:0] seq_len_c;
  logic [hss_pkg::PROB_W-1:0] q_sel;
  logic [SUM_W-1:0] sum_add;
  logic [DEV_W-1:0] dev_sel;
  logic             hit, walk_done, seq_last;
  logic [DEV_W-1:0] sdev_al, edev_al;

  assign busy                 = (state_r != hss_pkg::ST_IDLE);
  assign accept               = start && !busy;
  assign gen_accept           = accept && (in_kind == hss_pkg::KIND_GENERATE);
  assign out_valid            = out_valid_r;
  assign out_observation      = obs_r;
  assign out_hidden_state     = hid_r;
  assign out_last_in_sequence = last_r;
  assign pready               = 1'b1;

  // Configuration registers.
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[hss_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r  <= hss_pkg::NUM_STATES_RST;
      num_symbols_r <= hss_pkg::NUM_SYMBOLS_RST;
      seq_length_r  <= hss_pkg::SEQ_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        hss_pkg::REG_NUM_STATES:  num_states_r  <= pwdata[hss_pkg::NUM_W-1:0];
        hss_pkg::REG_NUM_SYMBOLS: num_symbols_r <= pwdata[hss_pkg::NUM_W-1:0];
        hss_pkg::REG_SEQ_LENGTH:  seq_length_r  <= pwdata[hss_pkg::SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hss_pkg::REG_NUM_STATES:  prdata = hss_pkg::APB_DW'(num_states_r);
      hss_pkg::REG_NUM_SYMBOLS: prdata = hss_pkg::APB_DW'(num_symbols_r);
      hss_pkg::REG_SEQ_LENGTH:  prdata = hss_pkg::APB_DW'(seq_length_r);
      default:                  prdata = '0;
    endcase
  end

  // Loads. Out-of-range rows and slots are dropped.
  assign row_ok  = (in_row_state < MAX_STATES);
  assign row_idx = ST_W'(in_row_state);
  assign tgt_sat = (in_target_state < MAX_STATES) ? ST_W'(in_target_state)
                                                  : ST_W'(MAX_STATES - 1);
  assign deg_sat = (in_out_count > MAX_OUT_DEGREE) ? DEG_W'(MAX_OUT_DEGREE)
                                                   : DEG_W'(in_out_count);
  assign emis_waddr  = EM_AW'(row_idx) * EM_AW'(MAX_SYMBOLS) + EM_AW'(in_slot);
  assign trans_waddr = TR_AW'(row_idx) * TR_AW'(MAX_OUT_DEGREE) + TR_AW'(in_slot);

  assign we_start = accept && row_ok && (in_kind == hss_pkg::KIND_LOAD_START);
  assign we_deg   = accept && row_ok && (in_kind == hss_pkg::KIND_LOAD_DEG);
  assign we_emis  = accept && row_ok && (in_slot < MAX_SYMBOLS)
                    && (in_kind == hss_pkg::KIND_LOAD_EMIT);
  assign we_trans = accept && row_ok && (in_slot < MAX_OUT_DEGREE)
                    && (in_kind == hss_pkg::KIND_LOAD_TRANS);

  // The walk reads one entry per cycle at the issue index of the current row.
  assign emis_raddr  = EM_AW'(cur_state_r) * EM_AW'(MAX_SYMBOLS) + EM_AW'(iss_r);
  assign trans_raddr = TR_AW'(cur_state_r) * TR_AW'(MAX_OUT_DEGREE) + TR_AW'(iss_r);

  always_ff @(posedge clk) begin
    if (we_start) start_mem[row_idx] <= in_prob;
    start_q <= start_mem[ST_W'(iss_r)];
  end

  always_ff @(posedge clk) begin
    if (we_deg) deg_mem[row_idx] <= deg_sat;
    deg_q <= deg_mem[cur_state_r];
  end

  always_ff @(posedge clk) begin
    if (we_emis) emis_mem[emis_waddr] <= in_prob;
    emis_q <= emis_mem[emis_raddr];
  end

  always_ff @(posedge clk) begin
    if (we_trans) trans_mem[trans_waddr] <= {tgt_sat, in_prob};
    trans_q <= trans_mem[trans_raddr];
  end

  // Counts clamped to their legal range.
  assign n_states_c  = (num_states_r == '0) ? CNT_W'(1)
                     : (num_states_r > MAX_STATES) ? CNT_W'(MAX_STATES)
                     : CNT_W'(num_states_r);
  assign n_symbols_c = (num_symbols_r == '0) ? CNT_W'(1)
                     : (num_symbols_r > MAX_SYMBOLS) ? CNT_W'(MAX_SYMBOLS)
                     : CNT_W'(num_symbols_r);
  assign seq_len_c   = (seq_length_r == '0) ? hss_pkg::SEQ_W'(1)
                     : (seq_length_r > hss_pkg::SEQ_LEN_MAX)
                       ? hss_pkg::SEQ_W'(hss_pkg::SEQ_LEN_MAX) : seq_length_r;

  assign sdev_al = (DEV_W'(in_state_deviate) << DEV_SHL) >> DEV_SHR;
  assign edev_al = (DEV_W'(in_emit_deviate) << DEV_SHL) >> DEV_SHR;

  // Shared accumulate-and-compare unit.
  always_comb begin
    case (state_r)
      hss_pkg::ST_PICK: q_sel = from_start_r ? start_q : trans_q[hss_pkg::PROB_W-1:0];
      default:          q_sel = emis_q;
    endcase
  end

  assign dev_sel   = (state_r == hss_pkg::ST_EMIT) ? edev_r : sdev_r;
  assign sum_add   = sum_r + SUM_W'(q_sel);
  assign hit       = (sum_add >= SUM_W'(dev_sel));
  assign last_idx  = n_r - CNT_W'(1);
  assign walk_done = dvld_r && (hit || (CNT_W'(didx_r) == last_idx));
  assign seq_last  = ((hss_pkg::SEQ_W'(pos_r) + hss_pkg::SEQ_W'(1)) >= seq_len_c);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hss_pkg::ST_IDLE: begin
        if (gen_accept) state_nxt = (pos_r == '0) ? hss_pkg::ST_PICK : hss_pkg::ST_DEG;
      end
      hss_pkg::ST_DEG: begin
        state_nxt = (deg_q == '0) ? hss_pkg::ST_EMIT : hss_pkg::ST_PICK;
      end
      hss_pkg::ST_PICK: begin
        if (walk_done) state_nxt = hss_pkg::ST_EMIT;
      end
      hss_pkg::ST_EMIT: begin
        if (walk_done) state_nxt = hss_pkg::ST_IDLE;
      end
      default: state_nxt = hss_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    iss_nxt        = iss_r;
    didx_nxt       = didx_r;
    dvld_nxt       = dvld_r;
    n_nxt          = n_r;
    sum_nxt        = sum_r;
    sdev_nxt       = sdev_r;
    edev_nxt       = edev_r;
    from_start_nxt = from_start_r;
    cur_state_nxt  = cur_state_r;
    pos_nxt        = pos_r;
    obs_nxt        = obs_r;
    hid_nxt        = hid_r;
    last_nxt       = last_r;
    out_valid_nxt  = 1'b0;

    case (state_r)
      hss_pkg::ST_IDLE: begin
        if (gen_accept) begin
          sdev_nxt       = sdev_al;
          edev_nxt       = edev_al;
          from_start_nxt = (pos_r == '0);
          n_nxt          = n_states_c;
          iss_nxt        = '0;
          dvld_nxt       = 1'b0;
          sum_nxt        = '0;
        end
      end
      hss_pkg::ST_DEG: begin
        // No slots means no transition: go straight to the emission walk.
        n_nxt    = (deg_q == '0) ? n_symbols_c : CNT_W'(deg_q);
        iss_nxt  = '0;
        dvld_nxt = 1'b0;
        sum_nxt  = '0;
      end
      hss_pkg::ST_PICK, hss_pkg::ST_EMIT: begin
        iss_nxt  = (CNT_W'(iss_r) == last_idx) ? iss_r : iss_r + IDX_W'(1);
        didx_nxt = iss_r;
        dvld_nxt = 1'b1;
        if (dvld_r) sum_nxt = sum_add;
        if (walk_done) begin
          if (state_r == hss_pkg::ST_PICK) begin
            cur_state_nxt = from_start_r ? ST_W'(didx_r)
                                         : trans_q[TR_DW-1:hss_pkg::PROB_W];
            n_nxt    = n_symbols_c;
            iss_nxt  = '0;
            dvld_nxt = 1'b0;
            sum_nxt  = '0;
          end else begin
            obs_nxt       = hss_pkg::OUT_IDX_W'(didx_r);
            hid_nxt       = hss_pkg::OUT_IDX_W'(cur_state_r);
            last_nxt      = seq_last;
            pos_nxt       = seq_last ? '0 : pos_r + hss_pkg::POS_W'(1);
            out_valid_nxt = 1'b1;
            dvld_nxt      = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hss_pkg::ST_IDLE;
      cur_state_r <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      dvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_state_r <= cur_state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      dvld_r      <= dvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    didx_r       <= didx_nxt;
    n_r          <= n_nxt;
    sum_r        <= sum_nxt;
    sdev_r       <= sdev_nxt;
    edev_r       <= edev_nxt;
    from_start_r <= from_start_nxt;
    obs_r        <= obs_nxt;
    hid_r        <= hid_nxt;
    last_r       <= last_nxt;
  end

  // A result strobe never stays high: it always drops again after it rises.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Every generate transaction ends with exactly one result.
  assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> out_valid)
    else $error("sequencer went idle without a result");

  // A generate transaction always occupies the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n) gen_accept |=> busy)
    else $error("generate transaction did not start the sequencer");

  // The last observation of a sequence rewinds the position.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_last_in_sequence) |-> (pos_r == '0))
    else $error("position not rewound after last observation");

endmodule
